// File: rtl/core/stt_pkg.sv
// Shared types and codes for the software timer table.
// No dependencies; compiled first.
package stt_pkg;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_DELETE = 3'd3,
    OP_TICK   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One timer entry as held in the slot memory.
  typedef struct packed {
    logic        active;
    logic        periodic;
    logic [31:0] id;
    logic [31:0] interval;
    logic [31:0] deadline;
  } slot_t;

  // One result transaction.
  typedef struct packed {
    status_e     status;
    logic [31:0] id;
    logic        fired;
    logic        last;
  } result_t;

endpackage

// File: rtl/core/stt_if.sv
// Valid/ready channel interfaces for the software timer table.
// Depends on nothing; compiled after stt_pkg.
interface stt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] target_id;
  logic [31:0] interval;
  logic        periodic;

  modport source (output valid, opcode, target_id, interval, periodic, input ready);
  modport sink   (input valid, opcode, target_id, interval, periodic, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_id;
  logic        fired;
  logic        last;

  modport source (output valid, status, result_id, fired, last, input ready);
  modport sink   (input valid, status, result_id, fired, last, output ready);
endinterface

// File: rtl/core/software_timer_table.sv
// Top level of the software timer table.
// Depends on stt_pkg, stt_if, stt_mem and stt_ctrl.
//
// Usage
//   in_i  : one transaction per operation (create, start, stop, delete,
//           tick). Accepted when valid and ready are both high; ready is
//           high while the sequencer is idle.
//   out_o : result transactions. Every operation yields one result,
//           except a tick, which yields one result per fired timer
//           (newest id first), or a single empty result if none fired.
//           The final result of each operation has last set.
// Operation
//   Timers sit in a slot memory, newest in slot 0, with registered reads;
//   the sequencer reads one slot per cycle unless a full output register holds a tick.
//   create  : shifts the stored entries down, writes the new one, responds.
//   start/stop/delete : scan from slot 0 for the id; delete then shifts
//             the entries behind the match up by one.
//   tick    : scans every stored slot, pausing on output stalls.
//   The single memory port pair bounds the rate to one slot per cycle.
// Reset: table empty, time zero, next id one; no clearing pass.
// Stall: a full output register holds the sequencer (a tick scan pauses
//   on its current slot); the next operation is taken as soon as the
//   previous one's last result sits in the output register.
module software_timer_table
  import stt_pkg::*;
#(
  parameter  int unsigned MAX_TIMERS = 16,
  localparam int unsigned AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  slot_t         rd_data;

  logic          emit_vld;
  result_t       emit;
  logic          out_space;

  logic          out_vld_q, out_vld_d;
  result_t       out_q;

  stt_mem #(
    .DEPTH (MAX_TIMERS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stt_ctrl #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_opcode_i    (in_i.opcode),
    .in_target_id_i (in_i.target_id),
    .in_interval_i  (in_i.interval),
    .in_periodic_i  (in_i.periodic),
    .out_space_i    (out_space),
    .emit_vld_o     (emit_vld),
    .emit_o         (emit),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_space = !out_vld_q || out_o.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit_vld) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_vld) begin
      out_q <= emit;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.status    = out_q.status;
  assign out_o.result_id = out_q.id;
  assign out_o.fired     = out_q.fired;
  assign out_o.last      = out_q.last;

endmodule

// File: rtl/core/stt_mem.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on stt_pkg (slot_t).
module stt_mem
  import stt_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  slot_t         wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output slot_t         rd_data_o
);

  slot_t mem_q [DEPTH];
  slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/stt_ctrl.sv
// Operation sequencer: scans the slot memory one entry per cycle (a tick
// pauses while the output is full), shifts entries on create/delete, fires timers on tick.
// Depends on stt_pkg; drives stt_mem.
module stt_ctrl
  import stt_pkg::*;
#(
  parameter  int unsigned MAX_TIMERS = 16,
  localparam int unsigned AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1,
  localparam int unsigned CW = $clog2(MAX_TIMERS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request side
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    in_opcode_i,
  input  logic [31:0]   in_target_id_i,
  input  logic [31:0]   in_interval_i,
  input  logic          in_periodic_i,
  // result side
  input  logic          out_space_i,
  output logic          emit_vld_o,
  output result_t       emit_o,
  // slot memory
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output slot_t         wr_data_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  slot_t         rd_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR_SHIFT,
    S_CR_NEW,
    S_FIND,
    S_DL_SHIFT,
    S_TICK,
    S_RESP
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   now_q, now_d;
  logic [31:0]   idc_q, idc_d;
  opcode_e       op_q, op_d;
  logic [31:0]   tid_q, tid_d;
  logic [31:0]   ivl_q, ivl_d;
  logic          per_q, per_d;
  logic          pend_vld_q, pend_vld_d;
  logic [31:0]   pend_id_q, pend_id_d;
  result_t       res_q, res_d;

  slot_t         ent;
  logic [CW-1:0] idx_nxt;
  logic          at_end;
  logic [31:0]   age;
  logic          due;
  logic          stall;

  assign ent     = rd_data_i;
  assign idx_nxt = CW'(idx_q) + CW'(1);
  assign at_end  = (idx_nxt == cnt_q);
  // wrap-safe deadline test
  assign age     = now_q - ent.deadline;
  assign due     = ent.active && !age[31];
  assign stall   = due && pend_vld_q && !out_space_i;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    idc_d      = idc_q;
    op_d       = op_q;
    tid_d      = tid_q;
    ivl_d      = ivl_q;
    per_d      = per_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    res_d      = res_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = '0;
    wr_data_o  = ent;
    emit_vld_o = 1'b0;
    emit_o     = '{status: ST_OK, id: pend_id_q, fired: 1'b1, last: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = opcode_e'(in_opcode_i);
          tid_d = in_target_id_i;
          ivl_d = in_interval_i;
          per_d = in_periodic_i;
          res_d = '{status: ST_OK, id: '0, fired: 1'b0, last: 1'b1};
          unique case (opcode_e'(in_opcode_i))
            OP_CREATE: begin
              if (in_interval_i == '0) begin
                res_d.status = ST_INVALID;
                state_d      = S_RESP;
              end else if (cnt_q == CW'(MAX_TIMERS)) begin
                res_d.status = ST_FULL;
                state_d      = S_RESP;
              end else if (cnt_q == '0) begin
                state_d = S_CR_NEW;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = AW'(cnt_q - CW'(1));
                idx_d     = AW'(cnt_q - CW'(1));
                state_d   = S_CR_SHIFT;
              end
            end
            OP_START, OP_STOP, OP_DELETE: begin
              if (cnt_q == '0) begin
                res_d.status = ST_NOT_FOUND;
                state_d      = S_RESP;
              end else begin
                rd_en_o = 1'b1;
                idx_d   = '0;
                state_d = S_FIND;
              end
            end
            OP_TICK: begin
              now_d      = now_q + 32'd1;
              pend_vld_d = 1'b0;
              if (cnt_q == '0) begin
                state_d = S_RESP;
              end else begin
                rd_en_o = 1'b1;
                idx_d   = '0;
                state_d = S_TICK;
              end
            end
            default: begin
              res_d.status = ST_INVALID;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      // move entries down by one, oldest first
      S_CR_SHIFT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = AW'(idx_nxt);
        if (idx_q == '0) begin
          state_d = S_CR_NEW;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = idx_q - AW'(1);
          idx_d     = idx_q - AW'(1);
        end
      end

      S_CR_NEW: begin
        wr_en_o   = 1'b1;
        wr_addr_o = '0;
        wr_data_o = '{active: 1'b0, periodic: per_q, id: idc_q, interval: ivl_q,
                      deadline: now_q + ivl_q};
        cnt_d     = cnt_q + CW'(1);
        res_d     = '{status: ST_OK, id: idc_q, fired: 1'b0, last: 1'b1};
        idc_d     = idc_q + 32'd1;
        state_d   = S_RESP;
      end

      // newest match wins: scan from slot 0
      S_FIND: begin
        if (ent.id == tid_q) begin
          res_d = '{status: ST_OK, id: '0, fired: 1'b0, last: 1'b1};
          unique case (op_q)
            OP_START: begin
              wr_en_o            = 1'b1;
              wr_addr_o          = idx_q;
              wr_data_o.active   = 1'b1;
              wr_data_o.deadline = now_q + ent.interval;
              state_d            = S_RESP;
            end
            OP_STOP: begin
              wr_en_o          = 1'b1;
              wr_addr_o        = idx_q;
              wr_data_o.active = 1'b0;
              state_d          = S_RESP;
            end
            default: begin
              if (at_end) begin
                cnt_d   = cnt_q - CW'(1);
                state_d = S_RESP;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = AW'(idx_nxt);
                idx_d     = AW'(idx_nxt);
                state_d   = S_DL_SHIFT;
              end
            end
          endcase
        end else if (at_end) begin
          res_d   = '{status: ST_NOT_FOUND, id: '0, fired: 1'b0, last: 1'b1};
          state_d = S_RESP;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(idx_nxt);
          idx_d     = AW'(idx_nxt);
        end
      end

      // close the gap left by a deleted entry
      S_DL_SHIFT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q - AW'(1);
        if (at_end) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_RESP;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(idx_nxt);
          idx_d     = AW'(idx_nxt);
        end
      end

      // one fired id is held back so the final one can carry last
      S_TICK: begin
        if (!stall) begin
          if (due) begin
            wr_en_o   = 1'b1;
            wr_addr_o = idx_q;
            if (ent.periodic) begin
              wr_data_o.deadline = now_q + ent.interval;
            end else begin
              wr_data_o.active = 1'b0;
            end
            emit_vld_o = pend_vld_q;
            pend_vld_d = 1'b1;
            pend_id_d  = ent.id;
          end
          if (at_end) begin
            res_d.status = ST_OK;
            res_d.id     = due ? ent.id : (pend_vld_q ? pend_id_q : '0);
            res_d.fired  = due || pend_vld_q;
            res_d.last   = 1'b1;
            pend_vld_d   = 1'b0;
            state_d      = S_RESP;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = AW'(idx_nxt);
            idx_d     = AW'(idx_nxt);
          end
        end
      end

      S_RESP: begin
        if (out_space_i) begin
          emit_vld_o = 1'b1;
          emit_o     = res_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      cnt_q      <= '0;
      now_q      <= '0;
      idc_q      <= 32'd1;
      op_q       <= OP_CREATE;
      tid_q      <= '0;
      ivl_q      <= '0;
      per_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_id_q  <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      now_q      <= now_d;
      idc_q      <= idc_d;
      op_q       <= op_d;
      tid_q      <= tid_d;
      ivl_q      <= ivl_d;
      per_q      <= per_d;
      pend_vld_q <= pend_vld_d;
      pend_id_q  <= pend_id_d;
      res_q      <= res_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_TIMERS))
    else $error("slot count above table size");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_o && rd_en_o) |-> (wr_addr_o != rd_addr_o))
    else $error("read and write hit the same slot in one cycle");

  a_emit_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_vld_o |-> out_space_i)
    else $error("result emitted into a full output register");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("held fired id left over after tick");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the software timer table.
// Depends on stt_pkg, stt_if and software_timer_table; compiled after them.
// Directed table first, then weighted random operations, all scored live.
module testbench;
  import stt_pkg::*;

  localparam int          MAX_TIMERS   = 16;
  localparam int          HALF_PERIOD  = 10;
  localparam int          RESET_CYCLES = 12;
  localparam int          NUM_RANDOM   = 335;
  // Wait after the last owed result for stray results; give it a healthy margin.
  localparam int          DRAIN_CYCLES = 4 * MAX_TIMERS + 8;
  // Watchdog limit, well above the slowest legal run: every tick firing all
  // sixteen timers, each result held by the longest receiver stall, plus gaps.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int          PHASE_LEN    = 50;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
  // Reserved opcodes; the block answers them with an invalid status.
  localparam logic [2:0]  OP_RSVD_LO = 3'd5;
  localparam logic [2:0]  OP_RSVD_HI = 3'd7;
  localparam logic        KNOWN      = 1'b1;
  localparam logic        PRED       = 1'b0;

  // One operation plus, for rows whose answer is obvious, the answer itself.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] target_id;
    logic [31:0] interval;
    logic        periodic;
    logic        known;
    status_e     exp_status;
    logic [31:0] exp_id;
  } stim_row_t;

  localparam int NUM_DIRECTED = 25;

  // Walk through every opcode, the field extremes and the special cases:
  // empty tick, unknown id, zero interval, reserved opcodes, wrap-safe
  // deadlines (huge intervals), stop of an idle timer, delete from the
  // middle of the table, one-shot and periodic expiry.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{OP_TICK,    32'd0,    32'd0,        1'b0, KNOWN, ST_OK,        32'd0},
    '{OP_START,   32'd1,    32'd0,        1'b0, KNOWN, ST_NOT_FOUND, 32'd0},
    '{OP_CREATE,  32'd0,    32'd0,        1'b1, KNOWN, ST_INVALID,   32'd0},
    '{OP_RSVD_LO, 32'd0,    32'd0,        1'b0, KNOWN, ST_INVALID,   32'd0},
    '{OP_RSVD_HI, ALL_ONES, ALL_ONES,     1'b1, KNOWN, ST_INVALID,   32'd0},
    '{OP_CREATE,  32'd0,    32'd1,        1'b0, KNOWN, ST_OK,        32'd1},
    '{OP_CREATE,  ALL_ONES, ALL_ONES,     1'b1, KNOWN, ST_OK,        32'd2},
    '{OP_CREATE,  32'd0,    HALF_RANGE,   1'b0, KNOWN, ST_OK,        32'd3},
    '{OP_START,   32'd1,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_START,   32'd2,    ALL_ONES,     1'b1, PRED,  ST_OK,        32'd0},
    '{OP_START,   32'd3,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_TICK,    ALL_ONES, ALL_ONES,     1'b1, PRED,  ST_OK,        32'd0},
    '{OP_TICK,    32'd0,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_STOP,    32'd2,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_STOP,    32'd1,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_DELETE,  32'd2,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_DELETE,  32'd2,    32'd0,        1'b0, KNOWN, ST_NOT_FOUND, 32'd0},
    '{OP_STOP,    32'd0,    32'd0,        1'b0, KNOWN, ST_NOT_FOUND, 32'd0},
    '{OP_DELETE,  ALL_ONES, 32'd0,        1'b0, KNOWN, ST_NOT_FOUND, 32'd0},
    '{OP_CREATE,  32'd0,    32'd2,        1'b1, KNOWN, ST_OK,        32'd4},
    '{OP_START,   32'd4,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_TICK,    32'd0,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_TICK,    32'd0,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_TICK,    32'd0,    32'd0,        1'b0, PRED,  ST_OK,        32'd0},
    '{OP_DELETE,  32'd1,    32'd0,        1'b0, PRED,  ST_OK,        32'd0}
  };

  logic clk_i;
  logic rst_ni;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  software_timer_table #(.MAX_TIMERS(MAX_TIMERS)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  int unsigned cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Shadow copy of the timer table; slot 0 holds the newest timer.
  logic        tbl_valid    [MAX_TIMERS];
  logic        tbl_active   [MAX_TIMERS];
  logic        tbl_periodic [MAX_TIMERS];
  logic [31:0] tbl_id       [MAX_TIMERS];
  logic [31:0] tbl_ivl      [MAX_TIMERS];
  logic [31:0] tbl_deadline [MAX_TIMERS];
  logic [31:0] now_ticks;
  logic [31:0] next_id;

  result_t step_results    [$];  // results of the operation just applied
  result_t pending_results [$];  // results still owed by the block
  int      error_count = 0;

  function automatic void move_entry(input int dst, input int src);
    tbl_valid[dst]    = tbl_valid[src];
    tbl_active[dst]   = tbl_active[src];
    tbl_periodic[dst] = tbl_periodic[src];
    tbl_id[dst]       = tbl_id[src];
    tbl_ivl[dst]      = tbl_ivl[src];
    tbl_deadline[dst] = tbl_deadline[src];
  endfunction

  // Apply one operation to the shadow table and collect what it reports.
  function automatic void timer_table_step(input stim_row_t it);
    int          n;
    int          s;
    logic [31:0] age;
    result_t     r;
    step_results.delete();
    r.status = ST_OK;
    r.id     = '0;
    r.fired  = 1'b0;
    r.last   = 1'b1;
    n = 0;
    for (int i = 0; i < MAX_TIMERS; i++)
      if (tbl_valid[i]) n++;
    // Newest match wins when ids repeat.
    s = -1;
    for (int i = MAX_TIMERS - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_id[i] == it.target_id) s = i;
    case (it.opcode)
      OP_CREATE: begin
        if (it.interval == '0) begin
          r.status = ST_INVALID;
        end else if (n >= MAX_TIMERS) begin
          r.status = ST_FULL;
        end else begin
          for (int i = n; i > 0; i--) move_entry(i, i - 1);
          tbl_valid[0]    = 1'b1;
          tbl_active[0]   = 1'b0;
          tbl_periodic[0] = it.periodic;
          tbl_id[0]       = next_id;
          tbl_ivl[0]      = it.interval;
          tbl_deadline[0] = now_ticks + it.interval;
          r.id    = next_id;
          next_id = next_id + 32'd1;
        end
        step_results.push_back(r);
      end
      OP_START, OP_STOP, OP_DELETE: begin
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (it.opcode == OP_START) begin
          tbl_active[s]   = 1'b1;
          tbl_deadline[s] = now_ticks + tbl_ivl[s];
        end else if (it.opcode == OP_STOP) begin
          tbl_active[s] = 1'b0;
        end else begin
          for (int i = s; i + 1 < n; i++) move_entry(i, i + 1);
          tbl_valid[n - 1]    = 1'b0;
          tbl_active[n - 1]   = 1'b0;
          tbl_periodic[n - 1] = 1'b0;
        end
        step_results.push_back(r);
      end
      OP_TICK: begin
        now_ticks = now_ticks + 32'd1;
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (tbl_valid[i] && tbl_active[i]) begin
            age = now_ticks - tbl_deadline[i];
            if (age < HALF_RANGE) begin
              r.id    = tbl_id[i];
              r.fired = 1'b1;
              r.last  = 1'b0;
              step_results.push_back(r);
              if (tbl_periodic[i]) tbl_deadline[i] = now_ticks + tbl_ivl[i];
              else tbl_active[i] = 1'b0;
            end
          end
        end
        if (step_results.size() == 0) begin
          step_results.push_back(r);
        end else begin
          r = step_results.pop_back();
          r.last = 1'b1;
          step_results.push_back(r);
        end
      end
      default: begin
        r.status = ST_INVALID;
        step_results.push_back(r);
      end
    endcase
  endfunction

  // Sender: directed rows, then random rows, in bursts with random gaps.
  initial begin
    stim_row_t   row;
    result_t     typed;
    int          burst_left;
    int          n_live;
    int          pick;
    logic        fill_phase;
    logic [31:0] live_ids [MAX_TIMERS];

    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_TICK;
    in_ch.target_id  <= '0;
    in_ch.interval   <= '0;
    in_ch.periodic   <= 1'b0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      tbl_valid[i]    = 1'b0;
      tbl_active[i]   = 1'b0;
      tbl_periodic[i] = 1'b0;
      tbl_id[i]       = '0;
      tbl_ivl[i]      = '0;
      tbl_deadline[i] = '0;
    end
    now_ticks = '0;
    next_id   = 32'd1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 8);
    for (int k = 0; k < NUM_DIRECTED + NUM_RANDOM; k++) begin
      if (k < NUM_DIRECTED) begin
        row = DIRECTED_ROWS[k];
      end else begin
        // Alternate fill and drain phases so the table both fills up
        // (table-full path) and empties again.
        fill_phase = (((k - NUM_DIRECTED) / PHASE_LEN) % 2) == 0;
        n_live = 0;
        for (int i = 0; i < MAX_TIMERS; i++)
          if (tbl_valid[i]) begin
            live_ids[n_live] = tbl_id[i];
            n_live++;
          end
        row.known      = PRED;
        row.exp_status = ST_OK;
        row.exp_id     = '0;
        row.periodic   = 1'($urandom_range(0, 1));

        pick = $urandom_range(0, 99);
        if (pick < (fill_phase ? 30 : 15))      row.opcode = OP_CREATE;
        else if (pick < (fill_phase ? 55 : 40)) row.opcode = OP_START;
        else if (pick < (fill_phase ? 62 : 50)) row.opcode = OP_STOP;
        else if (pick < (fill_phase ? 70 : 75)) row.opcode = OP_DELETE;
        else if (pick < 97)                     row.opcode = OP_TICK;
        else row.opcode = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));

        // Mostly live ids, a few just-deleted / not-yet-issued, a few noise.
        pick = $urandom_range(0, 9);
        if (pick < 8 && n_live > 0)
          row.target_id = live_ids[$urandom_range(0, n_live - 1)];
        else if (pick < 9)
          row.target_id = next_id - $urandom_range(0, 2);
        else
          row.target_id = $urandom;

        // Short intervals keep expiries frequent; the rest exercise zero and wrap.
        pick = $urandom_range(0, 19);
        if (pick < 14)       row.interval = $urandom_range(1, 6);
        else if (pick < 15)  row.interval = '0;
        else if (pick < 16)  row.interval = ALL_ONES - $urandom_range(0, 15);
        else                 row.interval = $urandom;
      end

      in_ch.valid     <= 1'b1;
      in_ch.opcode    <= row.opcode;
      in_ch.target_id <= row.target_id;
      in_ch.interval  <= row.interval;
      in_ch.periodic  <= row.periodic;
      @(posedge clk_i);
      while (in_ch.ready !== 1'b1) @(posedge clk_i);

      // Transaction accepted at this edge: update the shadow table.
      timer_table_step(row);
      if (row.known) begin
        typed.status = row.exp_status;
        typed.id     = row.exp_id;
        typed.fired  = 1'b0;
        typed.last   = 1'b1;
        pending_results.push_back(typed);
      end else begin
        foreach (step_results[j]) pending_results.push_back(step_results[j]);
      end

      burst_left--;
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    // Anything showing up now is an unexpected result.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: moves between randomly picked modes: always ready, coin flip,
  // one-in-four, and long random stalls.
  initial begin
    int mode;
    int stall_left;
    mode       = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (cycle_count % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (cycle_count % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  // Scoreboard: each accepted result against the oldest owed one.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display({"%0t: unexpected result, expected none, ",
                  "actual status %0d id %08h fired %0b last %0b"},
                 $time, out_ch.status, out_ch.result_id, out_ch.fired, out_ch.last);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.result_id !== want.id ||
            out_ch.fired !== want.fired || out_ch.last !== want.last) begin
          error_count++;
          $display({"%0t: result mismatch, ",
                    "expected status %0d id %08h fired %0b last %0b, ",
                    "actual status %0d id %08h fired %0b last %0b"},
                   $time, want.status, want.id, want.fired, want.last,
                   out_ch.status, out_ch.result_id, out_ch.fired, out_ch.last);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still owed", $time, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
